// ===== rtl/core/lwps_pkg.sv =====
package lwps_pkg;

  localparam int MaxPeers = 32;
  localparam int IdxW = $clog2(MaxPeers);
  localparam int CntW = $clog2(MaxPeers + 1);

  localparam int DreqW = 16;
  localparam int DlenW = 48;
  localparam int PreqW = 8;
  localparam int PlenW = 40;
  localparam int ScoreW = 50;

  localparam logic [1:0] CfgPeerCount = 2'd0;
  localparam logic [1:0] CfgDownMask  = 2'd1;
  localparam logic [1:0] CfgThreshold = 2'd2;

  typedef struct packed {
    logic [31:0] req_len;
    logic [15:0] random_value;
  } in_item_t;

  typedef struct packed {
    logic [4:0] peer_index;
    logic       no_peer;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MOD,
    ST_PICK,
    ST_MERGE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [DreqW-1:0] dreq;
    logic [DlenW-1:0] dlen;
    logic [PreqW-1:0] preq;
    logic [PlenW-1:0] plen;
  } peer_t;

endpackage

// ===== rtl/core/length_weighted_peer_selector.sv =====
// Length-weighted peer selector. Each request is handled alone: one pass over
// the live peers (one peer per cycle through a shared score adder) finds the
// minimum score and tie count, a remainder unit picks the tie slot, a second
// pass finds the winner, and when the merge threshold is reached a third pass
// folds the pending counts into the decayed totals; with no live peer up the
// result is no_peer. The second pass ends early when the winner comes before
// the last live peer. in_stall is high from acceptance until the result has
// been taken. The peer state resets to zero at once.
module length_weighted_peer_selector (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lwps_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lwps_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int IW = lwps_pkg::IdxW;
  localparam int CW = lwps_pkg::CntW;

  lwps_pkg::state_t state_r, state_nxt;
  lwps_pkg::peer_t  peers_r [lwps_pkg::MaxPeers];
  logic [5:0]       peer_count_r;
  logic [31:0]      down_mask_r;
  logic [7:0]       threshold_r;
  logic [7:0]       since_r, since_nxt;

  lwps_pkg::in_item_t  item_r;
  lwps_pkg::out_item_t res_r, res_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       ties_r, ties_nxt;
  logic [CW-1:0]       seen_r, seen_nxt;
  logic [CW-1:0]       pick_r, pick_nxt;
  logic [lwps_pkg::ScoreW-1:0] best_r, best_nxt;

  logic [CW-1:0]  live_n;
  logic           cur_up;
  logic [IW-1:0]  cur;
  lwps_pkg::peer_t cp;
  logic [lwps_pkg::ScoreW-1:0] score;
  logic           mod_start, mod_done;
  logic [CW-1:0]  mod_rem;
  logic           grant, merge_step;
  logic [IW-1:0]  win;
  logic [8:0]     since_inc;

  assign live_n = (peer_count_r > 6'(lwps_pkg::MaxPeers)) ?
                  CW'(lwps_pkg::MaxPeers) : CW'(peer_count_r);
  assign cur    = idx_r[IW-1:0];
  assign cp     = peers_r[cur];
  assign cur_up = !down_mask_r[cur];
  assign score  = lwps_pkg::ScoreW'(cp.dreq) + lwps_pkg::ScoreW'(cp.preq)
                + lwps_pkg::ScoreW'(cp.dlen) + lwps_pkg::ScoreW'(cp.plen)
                + lwps_pkg::ScoreW'(item_r.req_len);
  assign since_inc = {1'b0, since_r} + 9'd1;

  lwps_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (item_r.random_value),
    .divisor   (ties_r),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    ties_nxt   = ties_r;
    seen_nxt   = seen_r;
    pick_nxt   = pick_r;
    best_nxt   = best_r;
    res_nxt    = res_r;
    since_nxt  = since_r;
    mod_start  = 1'b0;
    grant      = 1'b0;
    merge_step = 1'b0;
    win        = cur;
    unique case (state_r)
      lwps_pkg::ST_IDLE: begin
        if (in_valid) begin
          idx_nxt   = '0;
          ties_nxt  = '0;
          state_nxt = lwps_pkg::ST_SCAN;
        end
      end
      lwps_pkg::ST_SCAN: begin
        if (idx_r >= live_n) begin
          if (ties_r == '0) begin
            res_nxt   = '{peer_index: '0, no_peer: 1'b1};
            state_nxt = lwps_pkg::ST_DONE;
          end else begin
            mod_start = 1'b1;
            state_nxt = lwps_pkg::ST_MOD;
          end
        end else begin
          if (cur_up) begin
            if (ties_r == '0 || score < best_r) begin
              best_nxt = score;
              ties_nxt = CW'(1);
            end else if (score == best_r) begin
              ties_nxt = ties_r + CW'(1);
            end
          end
          idx_nxt = idx_r + CW'(1);
        end
      end
      lwps_pkg::ST_MOD: begin
        if (mod_done) begin
          pick_nxt  = mod_rem;
          seen_nxt  = '0;
          idx_nxt   = '0;
          state_nxt = lwps_pkg::ST_PICK;
        end
      end
      lwps_pkg::ST_PICK: begin
        if (cur_up && score == best_r) begin
          if (seen_r == pick_r) begin
            grant     = 1'b1;
            res_nxt   = '{peer_index: 5'(cur), no_peer: 1'b0};
            idx_nxt   = '0;
            if (since_inc[7:0] >= threshold_r) begin
              since_nxt = '0;
              state_nxt = lwps_pkg::ST_MERGE;
            end else begin
              since_nxt = since_inc[7:0];
              state_nxt = lwps_pkg::ST_DONE;
            end
          end else begin
            seen_nxt = seen_r + CW'(1);
            idx_nxt  = idx_r + CW'(1);
          end
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      lwps_pkg::ST_MERGE: begin
        if (idx_r >= live_n) begin
          state_nxt = lwps_pkg::ST_DONE;
        end else begin
          merge_step = 1'b1;
          idx_nxt    = idx_r + CW'(1);
        end
      end
      lwps_pkg::ST_DONE: begin
        if (!out_stall) begin
          state_nxt = lwps_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lwps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lwps_pkg::ST_IDLE;
      peer_count_r <= 6'd32;
      down_mask_r  <= '0;
      threshold_r  <= 8'd64;
      since_r      <= '0;
    end else begin
      state_r <= state_nxt;
      since_r <= since_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          lwps_pkg::CfgPeerCount: peer_count_r <= cfg_data[5:0];
          lwps_pkg::CfgDownMask:  down_mask_r  <= cfg_data;
          lwps_pkg::CfgThreshold: threshold_r  <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
    if (state_r == lwps_pkg::ST_IDLE) begin
      item_r <= in_data;
    end
    idx_r  <= idx_nxt;
    ties_r <= ties_nxt;
    seen_r <= seen_nxt;
    pick_r <= pick_nxt;
    best_r <= best_nxt;
    res_r  <= res_nxt;
  end

  // Peer state: granted peer's pending counts grow, merge folds one peer a cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lwps_pkg::MaxPeers; i++) begin
        peers_r[i] <= '0;
      end
    end else if (grant) begin
      peers_r[win].preq <= (&cp.preq) ? cp.preq : cp.preq + 8'd1;
      peers_r[win].plen <= ({1'b0, cp.plen} + 41'(item_r.req_len) > 41'h0FF_FFFF_FFFF) ?
                           '1 : cp.plen + 40'(item_r.req_len);
    end else if (merge_step) begin
      peers_r[cur].dreq <= ({2'b0, cp.dreq[15:1]} + 17'(cp.preq) > 17'hFFFF) ?
                           '1 : (cp.dreq >> 1) + 16'(cp.preq);
      peers_r[cur].dlen <= ({1'b0, cp.dlen >> 1} + 49'(cp.plen) > 49'hFFFF_FFFF_FFFF) ?
                           '1 : (cp.dlen >> 1) + 48'(cp.plen);
      peers_r[cur].preq <= '0;
      peers_r[cur].plen <= '0;
    end
  end

  assign in_stall  = (state_r != lwps_pkg::ST_IDLE);
  assign out_valid = (state_r == lwps_pkg::ST_DONE);
  assign out_data  = res_r;
  assign cfg_ready = 1'b1;

endmodule

// ===== rtl/core/lwps_mod.sv =====
// Restoring remainder unit: one quotient bit per cycle over the 16-bit word.
module lwps_mod (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [15:0]                dividend,
  input  logic [lwps_pkg::CntW-1:0]  divisor,
  output logic                       done,
  output logic [lwps_pkg::CntW-1:0]  remainder
);

  logic [15:0]               dvd_r, dvd_nxt;
  logic [lwps_pkg::CntW:0]   rem_r, rem_nxt;
  logic [4:0]                cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic [lwps_pkg::CntW:0]   trial;

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r[lwps_pkg::CntW-1:0], dvd_r[15]};
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = 5'd16;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // Shift one dividend bit in and subtract when it fits.
      dvd_nxt = {dvd_r[14:0], 1'b0};
      rem_nxt = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = busy_r && (cnt_r == 5'd1);
  assign remainder = rem_nxt[lwps_pkg::CntW-1:0];

endmodule
